FILE: hdl/canonical_huffman_code_assigner_defines.svh
`ifndef CANONICAL_HUFFMAN_CODE_ASSIGNER_DEFINES_SVH
`define CANONICAL_HUFFMAN_CODE_ASSIGNER_DEFINES_SVH

// Assertion helpers, clocked on clk_i and disabled during reset
`define CHCA_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define CHCA_ASSERT(label, prop, msg) \
  `CHCA_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

FILE: hdl/chca_pkg.sv
`default_nettype none

package chca_pkg;

  localparam int unsigned SymbolsDef     = 512;
  localparam int unsigned MaxCodeBitsDef = 13;

  localparam int unsigned SymW  = 9;
  localparam int unsigned CodeW = 13;
  localparam int unsigned LenW  = 4;
  localparam int unsigned HistW = 10;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_EMIT = 1'b1
  } kind_e;

  typedef struct packed {
    logic inc;
    logic form;
    logic take;
    logic clear;
  } tab_op_t;

  function automatic logic [CodeW-1:0] code_mask(input logic [LenW-1:0] n);
    return ~({CodeW{1'b1}} << n);
  endfunction

  function automatic logic [CodeW-1:0] rev_code(input logic [CodeW-1:0] c,
                                                input logic [LenW-1:0] n);
    logic [CodeW-1:0] r;
    r = '0;
    for (int i = 0; i < CodeW; i++) begin
      if (LenW'(i) < n) begin
        r[i] = c[n - LenW'(1) - LenW'(i)];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/chca_if.sv
`default_nettype none

interface chca_in_if import chca_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            kind;
  logic [LenW-1:0] code_len_in;

  modport source (output valid, kind, code_len_in, input ready);
  modport sink   (input valid, kind, code_len_in, output ready);
endinterface

interface chca_out_if import chca_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SymW-1:0]  symbol_index;
  logic [CodeW-1:0] code_bits;
  logic [LenW-1:0]  code_len_out;
  logic             last;

  modport source (output valid, symbol_index, code_bits, code_len_out, last, input ready);
  modport sink   (input valid, symbol_index, code_bits, code_len_out, last, output ready);
endinterface

`default_nettype wire

FILE: hdl/chca_store.sv
`default_nettype none

module chca_store import chca_pkg::*; #(
  parameter int unsigned Depth = SymbolsDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [LenW-1:0]  wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [LenW-1:0]  rdata_o
);

  logic [LenW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/chca_table.sv
`default_nettype none

`include "canonical_huffman_code_assigner_defines.svh"

module chca_table import chca_pkg::*; #(
  parameter int unsigned MaxCodeBits = MaxCodeBitsDef,
  parameter int unsigned Entries     = MaxCodeBits + 1,
  parameter int unsigned TabW        = $clog2(Entries)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tab_op_t           op_i,
  input  wire logic [TabW-1:0]   addr_i,
  output logic      [CodeW-1:0]  rd_o
);

  // per length: symbol count while loading, next code after the start pass
  logic [CodeW-1:0] tab_q [Entries];
  logic [CodeW-1:0] acc_q;
  logic [CodeW-1:0] start;
  logic [HistW-1:0] cnt_inc;

  assign rd_o    = tab_q[addr_i];
  assign start   = {acc_q[CodeW-2:0], 1'b0};
  assign cnt_inc = rd_o[HistW-1:0] + HistW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) begin
        tab_q[i] <= '0;
      end
      acc_q <= '0;
    end else begin
      priority if (op_i.clear) begin
        for (int i = 0; i < Entries; i++) begin
          tab_q[i] <= '0;
        end
        acc_q <= '0;
      end else if (op_i.inc) begin
        tab_q[addr_i] <= CodeW'(cnt_inc);
      end else if (op_i.form) begin
        tab_q[addr_i] <= start;
        acc_q         <= start + CodeW'(rd_o[HistW-1:0]);
      end else if (op_i.take) begin
        tab_q[addr_i] <= rd_o + CodeW'(1);
      end
    end
  end

  `CHCA_ASSERT(a_form_addr_nonzero, op_i.form |-> addr_i != '0, "start pass on length zero")
  `CHCA_ASSERT(a_one_op, $onehot0({op_i.inc, op_i.form, op_i.take}), "overlapping table ops")
  `CHCA_ASSERT(a_clear_resets_acc, op_i.clear |=> acc_q == '0, "accumulator kept after clear")

endmodule

`default_nettype wire

FILE: hdl/canonical_huffman_code_assigner.sv
// Canonical Huffman code assigner. Feed one code length per symbol in symbol
// order (kind 0), then request codes (kind 1); each request returns the next
// symbol's canonical code, bit-reversed for an LSB-first stream, and the beat
// of the final symbol carries last and leaves the block empty for a new table.
// An emit reads the length store, which has a single registered read port, and
// then updates the per-length next-code table and registers the result. The
// first emit of a table also runs the pass that turns the length histogram
// into start codes. An emit also waits while the previous result has not been
// taken. Emits before all SYMBOLS lengths are loaded and loads into a full
// table are dropped without a result.
`default_nettype none

`include "canonical_huffman_code_assigner_defines.svh"

module canonical_huffman_code_assigner import chca_pkg::*; #(
  parameter int unsigned SYMBOLS       = SymbolsDef,
  parameter int unsigned MAX_CODE_BITS = MaxCodeBitsDef
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  chca_in_if.sink    in_i,
  chca_out_if.source out_o
);

  localparam int unsigned AddrW = $clog2(SYMBOLS);
  localparam int unsigned CntW  = $clog2(SYMBOLS + 1);
  localparam int unsigned TabW  = $clog2(MAX_CODE_BITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FORM,
    ST_LOOKUP
  } state_e;

  state_e           state_q;
  logic [CntW-1:0]  load_cnt_q;
  logic [AddrW-1:0] emit_cnt_q;
  logic             starts_ready_q;
  logic [TabW-1:0]  form_l_q;
  logic             out_valid_q;
  logic [SymW-1:0]  out_sym_q;
  logic [CodeW-1:0] out_code_q;
  logic [LenW-1:0]  out_len_q;
  logic             out_last_q;

  logic             beat_in;
  logic             load_full;
  logic             load_go;
  logic             emit_go;
  logic [LenW-1:0]  len_cl;
  logic [LenW-1:0]  st_len;
  logic             can_out;
  logic             done;
  logic             is_last;
  tab_op_t          tab_op;
  logic [TabW-1:0]  tab_addr;
  logic [CodeW-1:0] tab_rd;
  logic [CodeW-1:0] code_d;

  assign in_i.ready   = (state_q == ST_IDLE);
  assign beat_in      = in_i.valid & in_i.ready;
  assign load_full    = (load_cnt_q == CntW'(SYMBOLS));
  assign load_go      = beat_in & (in_i.kind == KIND_LOAD) & !load_full;
  assign emit_go      = beat_in & (in_i.kind == KIND_EMIT) & load_full;
  assign len_cl       = (in_i.code_len_in > LenW'(MAX_CODE_BITS)) ?
                        LenW'(MAX_CODE_BITS) : in_i.code_len_in;
  assign can_out      = !out_valid_q | out_o.ready;
  assign done         = (state_q == ST_LOOKUP) & can_out;
  assign is_last      = (emit_cnt_q == AddrW'(SYMBOLS - 1));

  chca_store #(
    .Depth (SYMBOLS),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_go),
    .waddr_i (load_cnt_q[AddrW-1:0]),
    .wdata_i (len_cl),
    .re_i    (emit_go),
    .raddr_i (emit_cnt_q),
    .rdata_o (st_len)
  );

  always_comb begin
    tab_op.inc   = load_go;
    tab_op.form  = (state_q == ST_FORM);
    tab_op.take  = done & (st_len != '0);
    tab_op.clear = done & is_last;
    unique case (state_q)
      ST_FORM:   tab_addr = form_l_q;
      ST_LOOKUP: tab_addr = TabW'(st_len);
      default:   tab_addr = TabW'(len_cl);
    endcase
  end

  chca_table #(
    .MaxCodeBits (MAX_CODE_BITS),
    .Entries     (MAX_CODE_BITS + 1),
    .TabW        (TabW)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (tab_op),
    .addr_i (tab_addr),
    .rd_o   (tab_rd)
  );

  assign code_d = rev_code(tab_rd & code_mask(st_len), st_len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      load_cnt_q     <= '0;
      emit_cnt_q     <= '0;
      starts_ready_q <= 1'b0;
      form_l_q       <= '0;
      out_valid_q    <= 1'b0;
      out_sym_q      <= '0;
      out_code_q     <= '0;
      out_len_q      <= '0;
      out_last_q     <= 1'b0;
    end else begin
      if (done && is_last) begin
        load_cnt_q <= '0;
      end else if (load_go) begin
        load_cnt_q <= load_cnt_q + CntW'(1);
      end
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (emit_go) begin
            form_l_q <= TabW'(1);
            state_q  <= starts_ready_q ? ST_LOOKUP : ST_FORM;
          end
        end
        ST_FORM: begin
          if (form_l_q == TabW'(MAX_CODE_BITS)) begin
            starts_ready_q <= 1'b1;
            state_q        <= ST_LOOKUP;
          end else begin
            form_l_q <= form_l_q + TabW'(1);
          end
        end
        ST_LOOKUP: begin
          if (can_out) begin
            out_sym_q   <= SymW'(emit_cnt_q);
            out_code_q  <= code_d;
            out_len_q   <= st_len;
            out_last_q  <= is_last;
            state_q     <= ST_IDLE;
            if (is_last) begin
              emit_cnt_q     <= '0;
              starts_ready_q <= 1'b0;
            end else begin
              emit_cnt_q <= emit_cnt_q + AddrW'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.symbol_index = out_sym_q;
  assign out_o.code_bits    = out_code_q;
  assign out_o.code_len_out = out_len_q;
  assign out_o.last         = out_last_q;

  `CHCA_ASSERT(a_busy_needs_full, state_q != ST_IDLE |-> load_full, "partial table")
  `CHCA_ASSERT(a_form_once, state_q == ST_FORM |-> !starts_ready_q, "start pass repeated")
  `CHCA_ASSERT(a_out_from_lookup, $rose(out_valid_q) |-> $past(state_q == ST_LOOKUP), "no lookup")
  `CHCA_ASSERT(a_last_clears, done && is_last |=> load_cnt_q == '0 && !starts_ready_q, "not cleared")

endmodule

`default_nettype wire
